FILE: rtl/segment_segment_closest_points_core_assert.svh
// Assertion macros shared by the closest-points core.
// Both macros assume clk_i and rst_ni in the enclosing module.
`ifndef SEGMENT_SEGMENT_CLOSEST_POINTS_CORE_ASSERT_SVH
`define SEGMENT_SEGMENT_CLOSEST_POINTS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SSCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SSCP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define SSCP_ASSERT(lbl, prop, msg)
`define SSCP_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: rtl/sscp_pkg.sv
package sscp_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_WIDTH     = 32;

  localparam int CW     = COORD_WIDTH;
  localparam int DFW    = CW + 1;        // coordinate difference
  localparam int PW     = 2 * DFW;       // difference product
  localparam int DOTW   = PW + 2;        // signed dot product
  localparam int MAGW   = PW;            // dot magnitude
  localparam int HW     = MAGW / 2;      // multiplier slice
  localparam int BPW    = 2 * MAGW;      // dot-by-dot magnitude
  localparam int DETW   = BPW + 2;       // signed det / numerators
  localparam int DIRW   = CW;            // direction magnitude
  localparam int NP     = BPW / HW;      // slices of a numerator
  localparam int PPW    = HW + DIRW;     // numerator slice times direction
  localparam int PRW    = BPW + DIRW;    // numerator times direction
  localparam int QB     = CW + 2;        // quotient bits
  localparam int DW     = BPW + 1 + QB;  // divider remainder
  localparam int LIMW   = 63;
  localparam int NCOORD = 6;
  localparam int NPTS   = 4;

  localparam int DOT_ST = 4;
  localparam int SOL_ST = 5;
  localparam int PL_ST  = QB + 4;

  localparam int IN_TW  = ((NPTS * 3 * CW + 7) / 8) * 8;
  localparam int OUT_TW = ((NCOORD * CW + 7) / 8) * 8;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_PARALLEL_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LIMIT     = CFG_IDX_W'(1);

  // dot product slots
  localparam int D_UU = 0;
  localparam int D_UV = 1;
  localparam int D_VV = 2;
  localparam int D_UW = 3;
  localparam int D_VW = 4;

  // exact one in the det scale
  localparam logic [BPW-1:0] ONE_DEN = BPW'(1) << (4 * COORD_FRAC_BITS);

  typedef struct packed {
    logic [NCOORD-1:0]           neg;
    logic [NCOORD-1:0][DIRW-1:0] mag;
    logic [NCOORD-1:0][CW-1:0]   base;
  } geom_t;

  typedef struct packed {
    logic [4:0][DOTW-1:0] val;
  } dots_t;

  typedef struct packed {
    logic [4:0]           neg;
    logic [4:0][MAGW-1:0] mag;
  } dmag_t;

  typedef struct packed {
    logic [BPW-1:0] snum;
    logic [BPW-1:0] sden;
    logic [BPW-1:0] tnum;
    logic [BPW-1:0] tden;
  } param_t;

  function automatic logic [PW-1:0] smul_diff(logic [DFW-1:0] a, logic [DFW-1:0] b);
    logic signed [PW-1:0] ea;
    logic signed [PW-1:0] eb;
    ea = $signed({{(PW-DFW){a[DFW-1]}}, a});
    eb = $signed({{(PW-DFW){b[DFW-1]}}, b});
    return ea * eb;
  endfunction

  function automatic logic [2*HW-1:0] umul_half(logic [HW-1:0] a, logic [HW-1:0] b);
    logic [2*HW-1:0] ea;
    logic [2*HW-1:0] eb;
    ea = {{HW{1'b0}}, a};
    eb = {{HW{1'b0}}, b};
    return ea * eb;
  endfunction

  function automatic logic signed [DETW-1:0] dot_to_det(logic [DOTW-1:0] x);
    return $signed({{(DETW-DOTW){x[DOTW-1]}}, x});
  endfunction

endpackage

FILE: rtl/segment_segment_closest_points_core.sv
// Closest points between two 3D segments, Q16.16 end points in, Q16.16 points out.
// Pipeline: sscp_dots, sscp_solve, then six sscp_place lanes, each with a one-bit-per-stage divider.
// Throughput: one segment pair per cycle; the whole pipeline halts while a result waits.
// Reset: asynchronous, active low; clears all valid bits and both limit registers.
// Limit registers are written any time over the config channel, which is always ready.
module segment_segment_closest_points_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // a_top_x, a_top_y, a_top_z, a_bottom_x..z, b_top_x..z, b_bottom_x..z
  input  logic [sscp_pkg::IN_TW-1:0]        s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pa_x, pa_y, pa_z, pb_x, pb_y, pb_z
  output logic [sscp_pkg::OUT_TW-1:0]       m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sscp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sscp_pkg::LIMW-1:0]         cfg_data_i
);
  import sscp_pkg::*;
  `include "segment_segment_closest_points_core_assert.svh"

  logic en;
  logic [LIMW-1:0] plimit_q, zlimit_q;
  logic [NPTS-1:0][2:0][CW-1:0] pts;

  logic   dots_vld, sol_vld;
  dots_t  dots;
  dmag_t  dmag;
  geom_t  geom_d, geom_s;
  param_t par;
  logic [NCOORD-1:0] place_vld;
  logic [NCOORD-1:0][CW-1:0] coords;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    for (int p = 0; p < NPTS; p++) begin
      for (int c = 0; c < 3; c++) begin
        pts[p][c] = s_axis_tdata[(p*3+c)*CW +: CW];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plimit_q <= '0;
      zlimit_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PARALLEL_LIMIT: plimit_q <= cfg_data_i;
        REG_ZERO_LIMIT:     zlimit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sscp_dots u_dots (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .pts_i   (pts),
    .valid_o (dots_vld),
    .dots_o  (dots),
    .dmag_o  (dmag),
    .geom_o  (geom_d)
  );

  sscp_solve u_solve (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (dots_vld),
    .dots_i   (dots),
    .dmag_i   (dmag),
    .geom_i   (geom_d),
    .plimit_i (plimit_q),
    .valid_o  (sol_vld),
    .par_o    (par),
    .geom_o   (geom_s)
  );

  for (genvar k = 0; k < NCOORD; k++) begin : g_place
    sscp_place u_place (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (sol_vld),
      .num_i     ((k < 3) ? par.snum : par.tnum),
      .den_i     ((k < 3) ? par.sden : par.tden),
      .zlimit_i  (zlimit_q),
      .dir_mag_i (geom_s.mag[k]),
      .dir_neg_i (geom_s.neg[k]),
      .base_i    (geom_s.base[k]),
      .valid_o   (place_vld[k]),
      .coord_o   (coords[k])
    );
  end

  assign m_axis_tvalid = place_vld[0];
  assign m_axis_tdata  = OUT_TW'(coords);

  `SSCP_ASSERT(a_lanes_in_step, place_vld == {NCOORD{place_vld[0]}}, "coordinate lanes out of step")
endmodule

FILE: rtl/sscp_dots.sv
module sscp_dots (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  logic                                     valid_i,
  input  logic [sscp_pkg::NPTS-1:0][2:0][sscp_pkg::CW-1:0] pts_i,
  output logic                                     valid_o,
  output sscp_pkg::dots_t                          dots_o,
  output sscp_pkg::dmag_t                          dmag_o,
  output sscp_pkg::geom_t                          geom_o
);
  import sscp_pkg::*;
  `include "segment_segment_closest_points_core_assert.svh"

  logic [DOT_ST-1:0] v_q;

  // stage 1: differences
  logic [2:0][DFW-1:0] u_d, v_d, w_d, u_q, v_q1, w_q;
  logic [2:0][CW-1:0]  ab_q, bb_q;

  // stage 2: products
  logic [4:0][2:0][PW-1:0] p_d, p_q;
  geom_t g_d, g2_q, g3_q, g4_q;

  // stage 3, 4
  dots_t d_d, d3_q, d4_q;
  dmag_t m_d, m_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_d[i] = {pts_i[0][i][CW-1], pts_i[0][i]} - {pts_i[1][i][CW-1], pts_i[1][i]};
      v_d[i] = {pts_i[2][i][CW-1], pts_i[2][i]} - {pts_i[3][i][CW-1], pts_i[3][i]};
      w_d[i] = {pts_i[1][i][CW-1], pts_i[1][i]} - {pts_i[3][i][CW-1], pts_i[3][i]};
    end
  end

  always_comb begin
    logic [DFW-1:0] nu, nv;
    for (int i = 0; i < 3; i++) begin
      p_d[D_UU][i] = smul_diff(u_q[i], u_q[i]);
      p_d[D_UV][i] = smul_diff(u_q[i], v_q1[i]);
      p_d[D_VV][i] = smul_diff(v_q1[i], v_q1[i]);
      p_d[D_UW][i] = smul_diff(u_q[i], w_q[i]);
      p_d[D_VW][i] = smul_diff(v_q1[i], w_q[i]);
      nu = -u_q[i];
      nv = -v_q1[i];
      g_d.neg[i]      = u_q[i][DFW-1];
      g_d.neg[3+i]    = v_q1[i][DFW-1];
      g_d.mag[i]      = u_q[i][DFW-1] ? nu[DIRW-1:0] : u_q[i][DIRW-1:0];
      g_d.mag[3+i]    = v_q1[i][DFW-1] ? nv[DIRW-1:0] : v_q1[i][DIRW-1:0];
      g_d.base[i]     = ab_q[i];
      g_d.base[3+i]   = bb_q[i];
    end
  end

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      d_d.val[k] = {{(DOTW-PW){p_q[k][0][PW-1]}}, p_q[k][0]}
                 + {{(DOTW-PW){p_q[k][1][PW-1]}}, p_q[k][1]}
                 + {{(DOTW-PW){p_q[k][2][PW-1]}}, p_q[k][2]};
    end
  end

  always_comb begin
    logic [DOTW-1:0] t;
    for (int k = 0; k < 5; k++) begin
      t = d3_q.val[k][DOTW-1] ? -d3_q.val[k] : d3_q.val[k];
      m_d.neg[k] = d3_q.val[k][DOTW-1];
      m_d.mag[k] = t[MAGW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DOT_ST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q  <= u_d;
      v_q1 <= v_d;
      w_q  <= w_d;
      ab_q <= pts_i[1];
      bb_q <= pts_i[3];
      p_q  <= p_d;
      g2_q <= g_d;
      d3_q <= d_d;
      g3_q <= g2_q;
      d4_q <= d3_q;
      m_q  <= m_d;
      g4_q <= g3_q;
    end
  end

  assign valid_o = v_q[DOT_ST-1];
  assign dots_o  = d4_q;
  assign dmag_o  = m_q;
  assign geom_o  = g4_q;

  `SSCP_ASSERT_NEXT(a_dots_hold, !en_i, $stable(v_q), "dots pipeline moved while stalled")
endmodule

FILE: rtl/sscp_solve.sv
module sscp_solve (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  sscp_pkg::dots_t             dots_i,
  input  sscp_pkg::dmag_t             dmag_i,
  input  sscp_pkg::geom_t             geom_i,
  input  logic [sscp_pkg::LIMW-1:0]   plimit_i,
  output logic                        valid_o,
  output sscp_pkg::param_t            par_o,
  output sscp_pkg::geom_t             geom_o
);
  import sscp_pkg::*;
  `include "segment_segment_closest_points_core_assert.svh"

  logic [SOL_ST-1:0] v_q;
  geom_t [SOL_ST-1:0] g_q;
  dots_t [2:0] d_q;

  // stage 5: slice products
  logic [5:0][MAGW-1:0] ma, mb;
  logic [5:0] sg_d, sg_q, sg6_q;
  logic [5:0][3:0][2*HW-1:0] pp_d, pp_q;
  // stage 6: magnitudes
  logic [5:0][BPW-1:0] bm_d, bm_q;
  // stage 7: signed terms
  logic signed [DETW-1:0] det_d, sn_d, tn_d, det_q, sn_q, tn_q;
  // stage 8: interior / parallel choice
  logic [BPW-1:0] snum1_d, sden1_d, snum1_q, sden1_q;
  logic signed [DETW-1:0] tnum1_d, tden1_d, tnum1_q, tden1_q;
  logic signed [DETW-1:0] val0_d, val1_d, uu_d, val0_q, val1_q, uu_q;
  // stage 9: edge clamps
  param_t par_d, par_q;

  always_comb begin
    ma[0] = dmag_i.mag[D_UU]; mb[0] = dmag_i.mag[D_VV];
    ma[1] = dmag_i.mag[D_UV]; mb[1] = dmag_i.mag[D_UV];
    ma[2] = dmag_i.mag[D_UV]; mb[2] = dmag_i.mag[D_VW];
    ma[3] = dmag_i.mag[D_VV]; mb[3] = dmag_i.mag[D_UW];
    ma[4] = dmag_i.mag[D_UU]; mb[4] = dmag_i.mag[D_VW];
    ma[5] = dmag_i.mag[D_UV]; mb[5] = dmag_i.mag[D_UW];
    sg_d[0] = dmag_i.neg[D_UU] ^ dmag_i.neg[D_VV];
    sg_d[1] = 1'b0;
    sg_d[2] = dmag_i.neg[D_UV] ^ dmag_i.neg[D_VW];
    sg_d[3] = dmag_i.neg[D_VV] ^ dmag_i.neg[D_UW];
    sg_d[4] = dmag_i.neg[D_UU] ^ dmag_i.neg[D_VW];
    sg_d[5] = dmag_i.neg[D_UV] ^ dmag_i.neg[D_UW];
    for (int k = 0; k < 6; k++) begin
      pp_d[k][0] = umul_half(ma[k][HW-1:0],    mb[k][HW-1:0]);
      pp_d[k][1] = umul_half(ma[k][HW-1:0],    mb[k][MAGW-1:HW]);
      pp_d[k][2] = umul_half(ma[k][MAGW-1:HW], mb[k][HW-1:0]);
      pp_d[k][3] = umul_half(ma[k][MAGW-1:HW], mb[k][MAGW-1:HW]);
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      bm_d[k] = BPW'(pp_q[k][0])
              + (BPW'(pp_q[k][1]) << HW)
              + (BPW'(pp_q[k][2]) << HW)
              + (BPW'(pp_q[k][3]) << (2 * HW));
    end
  end

  always_comb begin
    logic signed [DETW-1:0] sv [6];
    for (int k = 0; k < 6; k++) begin
      sv[k] = $signed({{(DETW-BPW){1'b0}}, bm_q[k]});
      if (sg6_q[k]) sv[k] = -sv[k];
    end
    det_d = sv[0] - sv[1];
    sn_d  = sv[2] - sv[3];
    tn_d  = sv[4] - sv[5];
  end

  always_comb begin
    logic signed [DETW-1:0] vw_e, uv_e, vv_e, uw_e, lim_e;
    vw_e  = dot_to_det(d_q[2].val[D_VW]);
    uv_e  = dot_to_det(d_q[2].val[D_UV]);
    vv_e  = dot_to_det(d_q[2].val[D_VV]);
    uw_e  = dot_to_det(d_q[2].val[D_UW]);
    uu_d  = dot_to_det(d_q[2].val[D_UU]);
    lim_e = $signed({{(DETW-LIMW){1'b0}}, plimit_i});
    val0_d = -uw_e;
    val1_d = uv_e - uw_e;
    if (det_q <= lim_e) begin
      snum1_d = '0;
      sden1_d = ONE_DEN;
      tnum1_d = vw_e;
      tden1_d = vv_e;
    end else begin
      sden1_d = det_q[BPW-1:0];
      tden1_d = det_q;
      if (sn_q[DETW-1]) begin
        snum1_d = '0;
        tnum1_d = vw_e;
        tden1_d = vv_e;
      end else if (sn_q > det_q) begin
        snum1_d = det_q[BPW-1:0];
        tnum1_d = vw_e + uv_e;
        tden1_d = vv_e;
      end else begin
        snum1_d = sn_q[BPW-1:0];
        tnum1_d = tn_q;
      end
    end
  end

  always_comb begin
    logic signed [DETW-1:0] val;
    logic clamp;
    par_d.snum = snum1_q;
    par_d.sden = sden1_q;
    par_d.tnum = tnum1_q[BPW-1:0];
    par_d.tden = tden1_q[BPW-1:0];
    clamp = 1'b0;
    val   = val0_q;
    if (tnum1_q[DETW-1]) begin
      par_d.tnum = '0;
      clamp = 1'b1;
    end else if (tnum1_q > tden1_q) begin
      par_d.tnum = tden1_q[BPW-1:0];
      clamp = 1'b1;
      val   = val1_q;
    end
    // t hit an edge: redo s against that edge
    if (clamp) begin
      if (val[DETW-1]) begin
        par_d.snum = '0;
      end else if (val > uu_q) begin
        par_d.snum = sden1_q;
      end else begin
        par_d.snum = val[BPW-1:0];
        par_d.sden = uu_q[BPW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[SOL_ST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g_q     <= {g_q[SOL_ST-2:0], geom_i};
      d_q     <= {d_q[1:0], dots_i};
      pp_q    <= pp_d;
      sg_q    <= sg_d;
      bm_q    <= bm_d;
      sg6_q   <= sg_q;
      det_q   <= det_d;
      sn_q    <= sn_d;
      tn_q    <= tn_d;
      snum1_q <= snum1_d;
      sden1_q <= sden1_d;
      tnum1_q <= tnum1_d;
      tden1_q <= tden1_d;
      val0_q  <= val0_d;
      val1_q  <= val1_d;
      uu_q    <= uu_d;
      par_q   <= par_d;
    end
  end

  assign valid_o = v_q[SOL_ST-1];
  assign par_o   = par_q;
  assign geom_o  = g_q[SOL_ST-1];

  `SSCP_ASSERT(a_num_le_den, !valid_o || (par_q.snum <= par_q.sden && par_q.tnum <= par_q.tden), "segment parameter numerator exceeds denominator")
endmodule

FILE: rtl/sscp_place.sv
module sscp_place (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [sscp_pkg::BPW-1:0]    num_i,
  input  logic [sscp_pkg::BPW-1:0]    den_i,
  input  logic [sscp_pkg::LIMW-1:0]   zlimit_i,
  input  logic [sscp_pkg::DIRW-1:0]   dir_mag_i,
  input  logic                        dir_neg_i,
  input  logic [sscp_pkg::CW-1:0]     base_i,
  output logic                        valid_o,
  output logic [sscp_pkg::CW-1:0]     coord_o
);
  import sscp_pkg::*;
  `include "segment_segment_closest_points_core_assert.svh"

  typedef struct packed {
    logic [DW-1:0]  rem;
    logic [BPW:0]   d2;
    logic [QB-1:0]  quo;
    logic           zero;
    logic           neg;
    logic [CW-1:0]  base;
  } div_t;

  logic [PL_ST-1:0] v_q;

  logic [NP-1:0][PPW-1:0] pp_d, pp_q;
  logic [BPW-1:0] den10_q, den11_q;
  logic zero10_q, zero11_q, neg10_q, neg11_q;
  logic [CW-1:0] base10_q, base11_q;
  logic [PRW-1:0] prod_d, prod_q;
  div_t st_d;
  div_t st_q [QB+1];
  logic [QB-1:0] q_fin;
  logic [CW-1:0] coord_d, coord_q;

  always_comb begin
    for (int j = 0; j < NP; j++) begin
      pp_d[j] = PPW'(num_i[j*HW +: HW]) * PPW'(dir_mag_i);
    end
  end

  always_comb begin
    prod_d = '0;
    for (int j = 0; j < NP; j++) begin
      prod_d = prod_d + (PRW'(pp_q[j]) << (j * HW));
    end
  end

  // round to nearest: (2*prod + den) / (2*den)
  always_comb begin
    st_d.rem  = DW'({prod_q, 1'b0}) + DW'(den11_q);
    st_d.d2   = {den11_q, 1'b0};
    st_d.quo  = '0;
    st_d.zero = zero11_q;
    st_d.neg  = neg11_q;
    st_d.base = base11_q;
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [DW-1:0] cmp;
    div_t nxt;
    always_comb begin
      cmp = DW'(st_q[j].d2) << (QB - 1 - j);
      nxt = st_q[j];
      if (st_q[j].rem >= cmp) begin
        nxt.rem = st_q[j].rem - cmp;
        nxt.quo = {st_q[j].quo[QB-2:0], 1'b1};
      end else begin
        nxt.quo = {st_q[j].quo[QB-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[j+1] <= nxt;
      end
    end
  end

  always_comb begin
    logic [CW-1:0] qc;
    q_fin = st_q[QB].zero ? '0 : st_q[QB].quo;
    qc    = q_fin[CW-1:0];
    coord_d = st_q[QB].base + (st_q[QB].neg ? -qc : qc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[PL_ST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q     <= pp_d;
      den10_q  <= den_i;
      zero10_q <= (num_i <= BPW'(zlimit_i));
      neg10_q  <= dir_neg_i;
      base10_q <= base_i;
      prod_q   <= prod_d;
      den11_q  <= den10_q;
      zero11_q <= zero10_q;
      neg11_q  <= neg10_q;
      base11_q <= base10_q;
      st_q[0]  <= st_d;
      coord_q  <= coord_d;
    end
  end

  assign valid_o = v_q[PL_ST-1];
  assign coord_o = coord_q;

  // offset along the segment never exceeds the direction length
  `SSCP_ASSERT(a_quo_bound, !v_q[PL_ST-2] || q_fin[QB-1:DIRW] == '0, "point offset beyond segment end")
endmodule
